// ----- rtl/core/bsrt_pkg.sv -----
// Shared types and constants of the backing store region table.
// Used by the region memory and by the top level; depends on nothing.
`timescale 1ns / 1ps

package bsrt_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int VADDR_W    = 32;
    localparam int PAGE_W     = 20;
    localparam int COUNT_W    = 9;
    localparam int PID_W      = 6;
    localparam int SID_W      = 3;
    localparam int OFFS_W     = 8;
    localparam int USERS_W    = 7;
    localparam int CMD_W      = 3;

    localparam logic [USERS_W-1:0] USERS_MAX = 7'd127;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC      = 3'd0,
        CMD_MAP        = 3'd1,
        CMD_LOOKUP     = 3'd2,
        CMD_FREE_STORE = 3'd3,
        CMD_FREE_PROC  = 3'd4,
        CMD_UNMAP      = 3'd5
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] base;
        logic [COUNT_W-1:0] length;
    } region_entry_t;

    localparam region_entry_t REGION_CLEAR = '0;

endpackage

// ----- rtl/core/bsrt_region_ram.sv -----
// Region memory: one entry per process and store, one write and one
// registered read per cycle. Depends on bsrt_pkg for the entry layout.
`timescale 1ns / 1ps

module bsrt_region_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  bsrt_pkg::region_entry_t wr_data,
    input  logic [ADDR_W-1:0]       rd_addr,
    output bsrt_pkg::region_entry_t rd_data
);

    bsrt_pkg::region_entry_t mem [DEPTH];
    bsrt_pkg::region_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/backing_store_region_table_top.sv -----
// Top level of the backing store region table: command sequencer, store
// state registers and output register. Depends on bsrt_pkg and bsrt_region_ram.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: one command per transfer (allocate, map, lookup,
//   free store, free process, unmap) with its operands. Result channel m_*:
//   exactly one result per command, in command order.
//   One command is worked at a time; s_ready is low while it runs.
//   Work per command before the result:
//     out-of-range and unused commands: none; map: one write; free store:
//     at most one write; allocate: one store tested per cycle, until a free one
//     lookup, unmap, free process: each store costs one region memory read
//     and one evaluation step; lookup and unmap stop at the first hit.
//   After reset the region memory is swept clear one entry per cycle,
//   all NUM_PROCS * NUM_STORES entries (512 by default), with s_ready low.
//   A finished result sits in an output register; the next command is
//   accepted while it waits, and that command's result is held back in the
//   sequencer until the receiver takes the earlier one with m_ready.
module backing_store_region_table_top #(
    parameter int NUM_STORES = 8,
    parameter int NUM_PROCS  = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bsrt_pkg::CMD_W-1:0]    s_cmd,
    input  logic [bsrt_pkg::PID_W-1:0]    s_process_id,
    input  logic [bsrt_pkg::SID_W-1:0]    s_store_id,
    input  logic [bsrt_pkg::PAGE_W-1:0]   s_page_number,
    input  logic [bsrt_pkg::COUNT_W-1:0]  s_page_count,
    input  logic [bsrt_pkg::VADDR_W-1:0]  s_virtual_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [bsrt_pkg::SID_W-1:0]    m_store_index,
    output logic [bsrt_pkg::OFFS_W-1:0]   m_page_offset
);

    localparam int NUM_REGIONS = NUM_PROCS * NUM_STORES;
    localparam int ADDR_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int IDX_W  = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_MAP,
        ST_FREES,
        ST_RD,
        ST_EV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic                        store_in_use_reg [NUM_STORES];
    logic                        store_in_use_next [NUM_STORES];
    logic [bsrt_pkg::PID_W-1:0]  store_owner_reg [NUM_STORES];
    logic [bsrt_pkg::PID_W-1:0]  store_owner_next [NUM_STORES];
    logic [bsrt_pkg::USERS_W-1:0] store_users_reg [NUM_STORES];
    logic [bsrt_pkg::USERS_W-1:0] store_users_next [NUM_STORES];

    bsrt_pkg::cmd_t               cmd_reg, cmd_next;
    logic [bsrt_pkg::PID_W-1:0]   pid_reg, pid_next;
    logic [bsrt_pkg::PAGE_W-1:0]  page_reg, page_next;
    logic [bsrt_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                         res_status_reg, res_status_next;
    logic [IDX_W-1:0]             res_sidx_reg, res_sidx_next;
    logic [bsrt_pkg::OFFS_W-1:0]  res_offs_reg, res_offs_next;

    logic                         m_valid_reg, m_valid_next;
    logic                         m_status_reg, m_status_next;
    logic [bsrt_pkg::SID_W-1:0]   m_sidx_reg, m_sidx_next;
    logic [bsrt_pkg::OFFS_W-1:0]  m_offs_reg, m_offs_next;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    bsrt_pkg::region_entry_t wr_data;
    logic [ADDR_W-1:0]       rd_addr;
    bsrt_pkg::region_entry_t rd_data;

    logic [ADDR_W-1:0]              scan_addr;
    logic [ADDR_W-1:0]              owner_addr;
    logic                           idx_last;
    logic                           pid_ok;
    logic                           sid_ok;
    logic                           hit;
    logic [bsrt_pkg::PAGE_W:0]      region_end;
    logic [bsrt_pkg::PAGE_W-1:0]    page_diff;
    logic [bsrt_pkg::USERS_W-1:0]   users_dec;
    logic                           out_free;

    bsrt_region_ram #(
        .DEPTH  (NUM_REGIONS),
        .ADDR_W (ADDR_W)
    ) u_region_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);

    assign scan_addr  = ADDR_W'(32'(pid_reg) * NUM_STORES + 32'(idx_reg));
    assign owner_addr = ADDR_W'(32'(store_owner_reg[idx_reg]) * NUM_STORES + 32'(idx_reg));
    assign idx_last   = (32'(idx_reg) == NUM_STORES - 1);
    assign pid_ok     = (32'(s_process_id) < NUM_PROCS);
    assign sid_ok     = (32'(s_store_id) < NUM_STORES);
    assign out_free   = !m_valid_reg || m_ready;

    // A region holds the page when base <= page < base + length; the end is
    // taken one bit wider so that it cannot wrap.
    assign region_end = {1'b0, rd_data.base} + (bsrt_pkg::PAGE_W + 1)'(rd_data.length);
    assign hit        = rd_data.valid && (page_reg >= rd_data.base)
                        && ({1'b0, page_reg} < region_end);
    assign page_diff  = page_reg - rd_data.base;

    assign users_dec = (rd_data.valid && (store_users_reg[idx_reg] != '0))
                       ? store_users_reg[idx_reg] - 1'b1 : store_users_reg[idx_reg];

    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        idx_next          = idx_reg;
        store_in_use_next = store_in_use_reg;
        store_owner_next  = store_owner_reg;
        store_users_next  = store_users_reg;
        cmd_next          = cmd_reg;
        pid_next          = pid_reg;
        page_next         = page_reg;
        count_next        = count_reg;
        res_status_next   = res_status_reg;
        res_sidx_next     = res_sidx_reg;
        res_offs_next     = res_offs_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_sidx_next       = m_sidx_reg;
        m_offs_next       = m_offs_reg;
        wr_en             = 1'b0;
        wr_addr           = scan_addr;
        wr_data           = bsrt_pkg::REGION_CLEAR;
        rd_addr           = scan_addr;

        case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == NUM_REGIONS - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = bsrt_pkg::cmd_t'(s_cmd);
                    pid_next        = s_process_id;
                    count_next      = s_page_count;
                    page_next       = s_page_number;
                    idx_next        = '0;
                    res_status_next = 1'b0;
                    res_sidx_next   = '0;
                    res_offs_next   = '0;
                    state_next      = ST_DONE;
                    case (s_cmd)
                        bsrt_pkg::CMD_ALLOC: begin
                            res_status_next = 1'b1;
                            state_next      = ST_ALLOC;
                        end
                        bsrt_pkg::CMD_MAP: begin
                            idx_next = IDX_W'(s_store_id);
                            if (pid_ok && sid_ok) begin
                                state_next = ST_MAP;
                            end
                        end
                        bsrt_pkg::CMD_LOOKUP, bsrt_pkg::CMD_UNMAP: begin
                            res_status_next = 1'b1;
                            if (s_cmd == bsrt_pkg::CMD_LOOKUP) begin
                                page_next = s_virtual_address[bsrt_pkg::VADDR_W-1:
                                                              bsrt_pkg::PAGE_SHIFT];
                            end
                            if (pid_ok) begin
                                state_next = ST_RD;
                            end
                        end
                        bsrt_pkg::CMD_FREE_STORE: begin
                            idx_next = IDX_W'(s_store_id);
                            if (sid_ok) begin
                                state_next = ST_FREES;
                            end
                        end
                        bsrt_pkg::CMD_FREE_PROC: begin
                            if (pid_ok) begin
                                state_next = ST_RD;
                            end
                        end
                        default: begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                if (!store_in_use_reg[idx_reg]) begin
                    res_status_next = 1'b0;
                    res_sidx_next   = idx_reg;
                    state_next      = ST_DONE;
                end else if (idx_last) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MAP: begin
                wr_en          = 1'b1;
                wr_data.valid  = 1'b1;
                wr_data.base   = page_reg;
                wr_data.length = count_reg;
                store_owner_next[idx_reg]  = pid_reg;
                store_in_use_next[idx_reg] = 1'b1;
                if (store_users_reg[idx_reg] < bsrt_pkg::USERS_MAX) begin
                    store_users_next[idx_reg] = store_users_reg[idx_reg] + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_FREES: begin
                // A store that is not in use has no owner, so no region is cleared.
                if (store_in_use_reg[idx_reg]) begin
                    wr_en   = 1'b1;
                    wr_addr = owner_addr;
                end
                store_in_use_next[idx_reg] = 1'b0;
                store_owner_next[idx_reg]  = '0;
                state_next = ST_DONE;
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                state_next = idx_last ? ST_DONE : ST_RD;
                idx_next   = idx_reg + 1'b1;
                if (cmd_reg == bsrt_pkg::CMD_FREE_PROC) begin
                    wr_en = 1'b1;
                    store_users_next[idx_reg] = users_dec;
                    if (users_dec == '0) begin
                        store_in_use_next[idx_reg] = 1'b0;
                        store_owner_next[idx_reg]  = '0;
                    end
                end else if (hit) begin
                    res_status_next = 1'b0;
                    res_sidx_next   = idx_reg;
                    res_offs_next   = page_diff[bsrt_pkg::OFFS_W-1:0];
                    wr_en           = (cmd_reg == bsrt_pkg::CMD_UNMAP);
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_sidx_next   = bsrt_pkg::SID_W'(res_sidx_reg);
                    m_offs_next   = res_offs_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STORES; i++) begin
                store_in_use_reg[i] <= 1'b0;
                store_owner_reg[i]  <= '0;
                store_users_reg[i]  <= '0;
            end
        end else begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            m_valid_reg      <= m_valid_next;
            store_in_use_reg <= store_in_use_next;
            store_owner_reg  <= store_owner_next;
            store_users_reg  <= store_users_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        cmd_reg        <= cmd_next;
        pid_reg        <= pid_next;
        page_reg       <= page_next;
        count_reg      <= count_next;
        res_status_reg <= res_status_next;
        res_sidx_reg   <= res_sidx_next;
        res_offs_reg   <= res_offs_next;
        m_status_reg   <= m_status_next;
        m_sidx_reg     <= m_sidx_next;
        m_offs_reg     <= m_offs_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_store_index = m_sidx_reg;
    assign m_page_offset = m_offs_reg;

    // Accepting a command leaves the idle state, so ready drops after each transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in two consecutive cycles");

    // Results are only loaded from the completion state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion state");

    // No result can exist while the region memory is being swept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !m_valid_reg && !s_ready)
        else $error("activity during region memory sweep");

    for (genvar g = 0; g < NUM_STORES; g++) begin : g_owner_chk
        // A free store never keeps an owner.
        assert property (@(posedge aclk) disable iff (!aresetn)
            !store_in_use_reg[g] |-> store_owner_reg[g] == '0)
            else $error("free store holds an owner");
    end

endmodule
